@@ src/can_bus_off_recovery_sequencer_macros.svh @@
// Assertion macros of the bus-off recovery sequencer, used by cbr_back.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CAN_BUS_OFF_RECOVERY_SEQUENCER_MACROS_SVH
`define CAN_BUS_OFF_RECOVERY_SEQUENCER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CBR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define CBR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/cbr_pkg.sv @@
// Shared types and constants of the bus-off recovery sequencer.
// Depends on nothing; used by the interfaces, the modules and the testbench.
package cbr_pkg;

	localparam int unsigned COUNTER_BITS_DEF = 32;
	localparam logic [15:0] RETRY_RESET = 16'd200;

	localparam logic [1:0] CMD_ERR    = 2'd0;
	localparam logic [1:0] CMD_TX     = 2'd1;
	localparam logic [1:0] CMD_POLL   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] LOG_EP   = 3'd0;
	localparam logic [2:0] LOG_BO   = 3'd1;
	localparam logic [2:0] LOG_OK   = 3'd2;
	localparam logic [2:0] LOG_FAIL = 3'd3;
	localparam logic [2:0] LOG_NONE = 3'd4;

	localparam logic [1:0] STEP_NONE   = 2'd0;
	localparam logic [1:0] STEP_STOP   = 2'd1;
	localparam logic [1:0] STEP_START  = 2'd2;
	localparam logic [1:0] STEP_NOTIFY = 2'd3;

	localparam logic [1:0] PH_STOP   = 2'd0;
	localparam logic [1:0] PH_START  = 2'd1;
	localparam logic [1:0] PH_NOTIFY = 2'd2;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        error_passive_flag;
		logic        bus_off_flag;
		logic        tx_nonzero;
		logic [31:0] status_reg;
		logic [31:0] error_count_reg;
		logic [31:0] tick_now;
		logic [1:0]  stop_result;
		logic [1:0]  start_result;
		logic [1:0]  notify_result;
	} cbr_item_t;

	typedef struct packed {
		logic [2:0]  log_kind;
		logic [31:0] log_arg_a;
		logic [31:0] log_arg_b;
	} cbr_log_t;

endpackage

@@ src/cbr_if.sv @@
// Valid/ready channel interfaces for the bus-off recovery sequencer.
// Depends on cbr_pkg for the default counter width.
interface cbr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic        error_passive_flag;
	logic        bus_off_flag;
	logic [31:0] tx_buffer_bits;
	logic [31:0] status_reg;
	logic [31:0] error_count_reg;
	logic [31:0] tick_now;
	logic [1:0]  stop_result;
	logic [1:0]  start_result;
	logic [1:0]  notify_result;

	modport source (output valid, cmd, error_passive_flag, bus_off_flag, tx_buffer_bits,
		status_reg, error_count_reg, tick_now, stop_result, start_result, notify_result,
		input ready);
	modport sink (input valid, cmd, error_passive_flag, bus_off_flag, tx_buffer_bits,
		status_reg, error_count_reg, tick_now, stop_result, start_result, notify_result,
		output ready);
endinterface

interface cbr_out_if #(parameter int unsigned COUNTER_BITS = cbr_pkg::COUNTER_BITS_DEF);
	logic                    valid;
	logic                    ready;
	logic [2:0]              log_kind;
	logic [31:0]             log_arg_a;
	logic [31:0]             log_arg_b;
	logic                    last;
	logic [2:0]              steps_issued;
	logic                    recovery_open;
	logic                    confirm_wait;
	logic [COUNTER_BITS-1:0] attempt_count;
	logic [COUNTER_BITS-1:0] success_count;
	logic [COUNTER_BITS-1:0] failure_count;
	logic [COUNTER_BITS-1:0] verify_fail_count;
	logic [COUNTER_BITS-1:0] bus_off_suppressed;

	modport source (output valid, log_kind, log_arg_a, log_arg_b, last, steps_issued,
		recovery_open, confirm_wait, attempt_count, success_count,
		failure_count, verify_fail_count, bus_off_suppressed, input ready);
	modport sink (input valid, log_kind, log_arg_a, log_arg_b, last, steps_issued,
		recovery_open, confirm_wait, attempt_count, success_count,
		failure_count, verify_fail_count, bus_off_suppressed, output ready);
endinterface

@@ src/cbr_front.sv @@
// Front part: accepts input beats, reduces them to compact items and queues them.
// Depends on cbr_pkg; feeds cbr_back through a two-entry queue.
module cbr_front (
	input  logic                clk,
	input  logic                arst_n,
	cbr_in_if.sink              in_ch,
	output logic                q_valid,
	input  logic                q_pop,
	output cbr_pkg::cbr_item_t  q_item
);

	cbr_pkg::cbr_item_t mem_q [cbr_pkg::QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cbr_pkg::cbr_item_t item;

	assign in_ch.ready = (count_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (count_q != 2'd0);
	assign q_item      = mem_q[rd_ptr_q];

	always_comb begin
		item.cmd                = in_ch.cmd;
		item.error_passive_flag = in_ch.error_passive_flag;
		item.bus_off_flag       = in_ch.bus_off_flag;
		item.tx_nonzero         = (in_ch.tx_buffer_bits != 32'd0);
		item.status_reg         = in_ch.status_reg;
		item.error_count_reg    = in_ch.error_count_reg;
		item.tick_now           = in_ch.tick_now;
		item.stop_result        = in_ch.stop_result;
		item.start_result       = in_ch.start_result;
		item.notify_result      = in_ch.notify_result;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

@@ src/cbr_back.sv @@
// Back part: runs the recovery bookkeeping for each queued item and drains its log beats.
// Depends on cbr_pkg, cbr_out_if and the assertion macros.
`include "can_bus_off_recovery_sequencer_macros.svh"

module cbr_back #(
	parameter int unsigned COUNTER_BITS = cbr_pkg::COUNTER_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               q_valid,
	output logic               q_pop,
	input  cbr_pkg::cbr_item_t q_item,
	cbr_out_if.source          out_ch
);

	localparam int unsigned CB = COUNTER_BITS;

	logic [15:0]   retry_q;
	logic [CB-1:0] bo_ev_q, ep_ev_q, tx_ev_q;
	logic [31:0]   ep_psr_q, ep_ecr_q, bo_psr_q, bo_ecr_q;
	logic [CB-1:0] handled_q, sched_q, logged_bo_q, logged_ep_q;
	logic [CB-1:0] vbo_q, vtx_q;
	logic [31:0]   next_att_q;
	logic          verifying_q, episode_q;
	logic [1:0]    phase_q;
	logic [CB-1:0] att_q, succ_q, fail_q, vfail_q, bosup_q, epsup_q;
	logic [1:0]    lf_step_q, lf_code_q;

	// Output buffer holding the log beats of one item.
	cbr_pkg::cbr_log_t logs_q [3];
	logic [1:0] nlog_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic [2:0] steps_q;

	// Next-state values.
	logic [CB-1:0] bo_ev_d, ep_ev_d, tx_ev_d;
	logic [31:0]   ep_psr_d, ep_ecr_d, bo_psr_d, bo_ecr_d;
	logic [CB-1:0] handled_d, sched_d, logged_bo_d, logged_ep_d, vbo_d, vtx_d;
	logic [31:0]   next_att_d;
	logic          verifying_d, episode_d;
	logic [1:0]    phase_d;
	logic [CB-1:0] att_d, succ_d, fail_d, vfail_d, bosup_d, epsup_d;
	logic [1:0]    lf_step_d, lf_code_d;
	cbr_pkg::cbr_log_t logs_d [3];
	logic [1:0]    nlog_d;
	logic [2:0]    steps_d;
	logic [CB-1:0] n;
	logic [31:0]   diff;
	logic          run, fail_hit, halt;
	logic [1:0]    f_step, f_code;
	logic          last_beat;

	assign last_beat = (idx_q == nlog_q - 2'd1);
	assign q_pop     = q_valid && (!busy_q || (out_ch.ready && last_beat));

	always_comb begin
		bo_ev_d = bo_ev_q; ep_ev_d = ep_ev_q; tx_ev_d = tx_ev_q;
		ep_psr_d = ep_psr_q; ep_ecr_d = ep_ecr_q; bo_psr_d = bo_psr_q; bo_ecr_d = bo_ecr_q;
		handled_d = handled_q; sched_d = sched_q;
		logged_bo_d = logged_bo_q; logged_ep_d = logged_ep_q;
		vbo_d = vbo_q; vtx_d = vtx_q; next_att_d = next_att_q;
		verifying_d = verifying_q; episode_d = episode_q; phase_d = phase_q;
		att_d = att_q; succ_d = succ_q; fail_d = fail_q;
		vfail_d = vfail_q; bosup_d = bosup_q; epsup_d = epsup_q;
		lf_step_d = lf_step_q; lf_code_d = lf_code_q;
		for (int i = 0; i < 3; i++) begin
			logs_d[i] = '{cbr_pkg::LOG_NONE, 32'd0, 32'd0};
		end
		nlog_d = 2'd0; steps_d = 3'd0;
		n = '0; diff = '0; run = 1'b0; fail_hit = 1'b0; halt = 1'b0;
		f_step = cbr_pkg::STEP_NONE; f_code = 2'd0;

		unique case (q_item.cmd)
			cbr_pkg::CMD_ERR: begin
				if (q_item.error_passive_flag) begin
					ep_psr_d = q_item.status_reg;
					ep_ecr_d = q_item.error_count_reg;
					ep_ev_d  = ep_ev_q + 1'b1;
				end
				if (q_item.bus_off_flag) begin
					bo_psr_d = q_item.status_reg;
					bo_ecr_d = q_item.error_count_reg;
					bo_ev_d  = bo_ev_q + 1'b1;
				end
			end
			cbr_pkg::CMD_TX: begin
				if (q_item.tx_nonzero) begin
					tx_ev_d = tx_ev_q + 1'b1;
				end
			end
			cbr_pkg::CMD_POLL: begin
				if (ep_ev_q != logged_ep_q) begin
					n = ep_ev_q - logged_ep_q;
					if (!episode_q) begin
						logs_d[nlog_d] = '{cbr_pkg::LOG_EP, ep_psr_q, ep_ecr_q};
						nlog_d = nlog_d + 2'd1;
						if (n > 1) begin
							epsup_d = epsup_d + n - 1'b1;
						end
					end else begin
						epsup_d = epsup_d + n;
					end
					logged_ep_d = ep_ev_q;
				end
				if (bo_ev_q != sched_q) begin
					if (logged_bo_q != bo_ev_q) begin
						n = bo_ev_q - logged_bo_q;
						if (!episode_q) begin
							logs_d[nlog_d] = '{cbr_pkg::LOG_BO, bo_psr_q, bo_ecr_q};
							nlog_d = nlog_d + 2'd1;
							episode_d = 1'b1;
							if (n > 1) begin
								bosup_d = bosup_d + n - 1'b1;
							end
						end else begin
							bosup_d = bosup_d + n;
						end
						logged_bo_d = bo_ev_q;
					end
					if (verifying_q) begin
						verifying_d = 1'b0;
						vfail_d = vfail_d + 1'b1;
					end
					sched_d = bo_ev_q;
					next_att_d = q_item.tick_now + {16'd0, retry_q};
				end
				if (verifying_d) begin
					if (tx_ev_q != vtx_q && bo_ev_q == vbo_q) begin
						handled_d = vbo_q;
						verifying_d = 1'b0;
						episode_d = 1'b0;
						succ_d = succ_d + 1'b1;
						lf_step_d = cbr_pkg::STEP_NONE;
						lf_code_d = 2'd0;
						logs_d[nlog_d] = '{cbr_pkg::LOG_OK, q_item.status_reg,
							q_item.error_count_reg};
						nlog_d = nlog_d + 2'd1;
					end
				end else if (sched_d != handled_d) begin
					diff = q_item.tick_now - next_att_d;
					run = !diff[31];
				end
				if (run) begin
					next_att_d = q_item.tick_now + {16'd0, retry_q};
					att_d = att_d + 1'b1;
					if (phase_q == cbr_pkg::PH_STOP) begin
						steps_d[0] = 1'b1;
						if (q_item.stop_result != 2'd0) begin
							fail_hit = 1'b1; f_step = cbr_pkg::STEP_STOP;
							f_code = q_item.stop_result; halt = 1'b1;
						end else begin
							phase_d = cbr_pkg::PH_START;
						end
					end
					if (!halt && phase_d == cbr_pkg::PH_START) begin
						steps_d[1] = 1'b1;
						if (q_item.start_result != 2'd0) begin
							fail_hit = 1'b1; f_step = cbr_pkg::STEP_START;
							f_code = q_item.start_result; halt = 1'b1;
						end else begin
							phase_d = cbr_pkg::PH_NOTIFY;
						end
					end
					if (!halt) begin
						steps_d[2] = 1'b1;
						if (q_item.notify_result != 2'd0) begin
							fail_hit = 1'b1; f_step = cbr_pkg::STEP_NOTIFY;
							f_code = q_item.notify_result;
						end else begin
							phase_d = cbr_pkg::PH_STOP;
							lf_step_d = cbr_pkg::STEP_NONE;
							lf_code_d = 2'd0;
							vbo_d = sched_d;
							vtx_d = tx_ev_q;
							verifying_d = 1'b1;
						end
					end
					if (fail_hit) begin
						fail_d = fail_d + 1'b1;
						if (lf_step_q != f_step || lf_code_q != f_code) begin
							logs_d[nlog_d] = '{cbr_pkg::LOG_FAIL, {30'd0, f_step},
								{30'd0, f_code}};
							nlog_d = nlog_d + 2'd1;
						end
						lf_step_d = f_step;
						lf_code_d = f_code;
					end
				end
			end
			default: begin
			end
		endcase
		if (nlog_d == 2'd0) begin
			nlog_d = 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ep_psr_q <= ep_psr_d; ep_ecr_q <= ep_ecr_d;
			bo_psr_q <= bo_psr_d; bo_ecr_q <= bo_ecr_d;
			for (int i = 0; i < 3; i++) begin
				logs_q[i] <= logs_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_q <= cbr_pkg::RETRY_RESET;
			bo_ev_q <= '0; ep_ev_q <= '0; tx_ev_q <= '0;
			handled_q <= '0; sched_q <= '0; logged_bo_q <= '0; logged_ep_q <= '0;
			vbo_q <= '0; vtx_q <= '0; next_att_q <= '0;
			verifying_q <= 1'b0; episode_q <= 1'b0; phase_q <= cbr_pkg::PH_STOP;
			att_q <= '0; succ_q <= '0; fail_q <= '0;
			vfail_q <= '0; bosup_q <= '0; epsup_q <= '0;
			lf_step_q <= cbr_pkg::STEP_NONE; lf_code_q <= 2'd0;
			nlog_q <= 2'd1; idx_q <= 2'd0; busy_q <= 1'b0; steps_q <= 3'd0;
		end else begin
			if (cfg_we) begin
				retry_q <= cfg_wdata;
			end
			if (q_pop) begin
				bo_ev_q <= bo_ev_d; ep_ev_q <= ep_ev_d; tx_ev_q <= tx_ev_d;
				handled_q <= handled_d; sched_q <= sched_d;
				logged_bo_q <= logged_bo_d; logged_ep_q <= logged_ep_d;
				vbo_q <= vbo_d; vtx_q <= vtx_d; next_att_q <= next_att_d;
				verifying_q <= verifying_d; episode_q <= episode_d; phase_q <= phase_d;
				att_q <= att_d; succ_q <= succ_d; fail_q <= fail_d;
				vfail_q <= vfail_d; bosup_q <= bosup_d; epsup_q <= epsup_d;
				lf_step_q <= lf_step_d; lf_code_q <= lf_code_d;
				nlog_q <= nlog_d; idx_q <= 2'd0; busy_q <= 1'b1; steps_q <= steps_d;
			end else if (busy_q && out_ch.ready) begin
				if (last_beat) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	assign out_ch.valid              = busy_q;
	assign out_ch.log_kind           = logs_q[idx_q].log_kind;
	assign out_ch.log_arg_a          = logs_q[idx_q].log_arg_a;
	assign out_ch.log_arg_b          = logs_q[idx_q].log_arg_b;
	assign out_ch.last               = last_beat;
	assign out_ch.steps_issued       = steps_q;
	assign out_ch.recovery_open      = (sched_q != handled_q) || verifying_q;
	assign out_ch.confirm_wait       = verifying_q;
	assign out_ch.attempt_count      = att_q;
	assign out_ch.success_count      = succ_q;
	assign out_ch.failure_count      = fail_q;
	assign out_ch.verify_fail_count  = vfail_q;
	assign out_ch.bus_off_suppressed = bosup_q;

	`CBR_ASSERT_IMP(a_idx_range, clk, arst_n, busy_q, idx_q < nlog_q, "beat index past item")
	`CBR_ASSERT_IMP(a_phase_ok, clk, arst_n, 1'b1, phase_q != 2'd3, "unused phase reached")
	`CBR_ASSERT_NXT(a_hold, clk, arst_n, busy_q && !out_ch.ready, busy_q && $stable(idx_q),
		"beat dropped under stall")
	`CBR_ASSERT_IMP(a_verify_pend, clk, arst_n, verifying_q,
		out_ch.recovery_open, "verification without pending recovery")

endmodule

@@ src/can_bus_off_recovery_sequencer.sv @@
// Top level of the CAN bus-off recovery sequencer.
// Depends on cbr_pkg, cbr_if, cbr_front and cbr_back.
//
// Usage: items arrive on the in_ch valid/ready channel; each is an error-status
// event, a transmit completion, a main-loop poll or an unused command. Every
// item yields one to three log beats on out_ch, the final one marked by last;
// all beats of an item carry the same status counters. The retry interval
// register is written through cfg_we and cfg_wdata while the block is idle;
// the user must keep to this, as the block does not enforce it. An accepted
// beat enters a two-entry queue; the back end pops it when idle or as the last
// beat of the previous item is taken, and registers its log beats and counters.
// While the receiver is ready, the back end takes one item per cycle for
// single-beat items and sends the beats of a longer item one per cycle.
// When the receiver stalls, the current beat holds, the queue fills and then
// in_ch.ready drops. Reset clears all counters, the queue and out_ch.valid,
// and loads the retry interval with 200 ticks.
module can_bus_off_recovery_sequencer #(
	parameter int unsigned COUNTER_BITS = cbr_pkg::COUNTER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	cbr_in_if.sink      in_ch,
	cbr_out_if.source   out_ch
);

	logic               q_valid;
	logic               q_pop;
	cbr_pkg::cbr_item_t q_item;

	cbr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item)
	);

	cbr_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_ch    (out_ch)
	);

endmodule

@@ dv/testbench.sv @@
// Testbench for the CAN bus-off recovery sequencer: directed and random items,
// a scoreboard that predicts every log beat, and random stalls on both channels.
// Depends on cbr_pkg, cbr_if and can_bus_off_recovery_sequencer.
`timescale 1ns / 100ps

typedef struct {
	logic [1:0]  cmd;
	logic        ep;
	logic        bo;
	logic [31:0] tx_bits;
	logic [31:0] status;
	logic [31:0] errcnt;
	logic [31:0] tick;
	logic [1:0]  stop_res;
	logic [1:0]  start_res;
	logic [1:0]  notify_res;
} sq_item_t;

typedef struct packed {
	logic [2:0]  kind;
	logic [31:0] arg_a;
	logic [31:0] arg_b;
	logic        last;
	logic [2:0]  steps;
	logic        rec_pend;
	logic        ver_pend;
	logic [31:0] attempts;
	logic [31:0] successes;
	logic [31:0] failures;
	logic [31:0] verify_fails;
	logic [31:0] bo_suppressed;
} log_beat_t;

class recovery_scoreboard;
	log_beat_t   expected_beats[$];
	int          errors;
	logic [15:0] interval;
	logic [31:0] bo_cnt, ep_cnt, tx_cnt;
	logic [31:0] ep_psr, ep_ecr, bo_psr, bo_ecr;
	logic [31:0] handled, scheduled, logged_b, logged_e;
	logic [31:0] snap_bo, snap_tx, due_tick;
	logic        verifying, in_episode;
	logic [1:0]  phase;
	logic [31:0] n_att, n_succ, n_fail, n_vfail, n_bosup;
	logic [1:0]  fail_step, fail_code;
	logic [2:0]  kinds[$];
	logic [31:0] args_a[$], args_b[$];

	function new();
		errors = 0;
		interval = cbr_pkg::RETRY_RESET;
		bo_cnt = 0; ep_cnt = 0; tx_cnt = 0;
		ep_psr = 0; ep_ecr = 0; bo_psr = 0; bo_ecr = 0;
		handled = 0; scheduled = 0; logged_b = 0; logged_e = 0;
		snap_bo = 0; snap_tx = 0; due_tick = 0;
		verifying = 0; in_episode = 0; phase = cbr_pkg::PH_STOP;
		n_att = 0; n_succ = 0; n_fail = 0; n_vfail = 0; n_bosup = 0;
		fail_step = cbr_pkg::STEP_NONE; fail_code = 0;
	endfunction

	function void add_log(logic [2:0] k, logic [31:0] a, logic [31:0] b);
		if (kinds.size() < 3) begin
			kinds.push_back(k);
			args_a.push_back(a);
			args_b.push_back(b);
		end
	endfunction

	function void note_failure(logic [1:0] step, logic [1:0] code);
		logic fresh;
		fresh = (fail_step != step) || (fail_code != code);
		n_fail++;
		fail_step = step;
		fail_code = code;
		if (fresh)
			add_log(cbr_pkg::LOG_FAIL, 32'(step), 32'(code));
	endfunction

	function logic [2:0] run_poll(sq_item_t it);
		logic [31:0] n;
		logic [31:0] diff;
		logic [2:0] steps;
		steps = 0;
		if (ep_cnt != logged_e) begin
			if (!in_episode)
				add_log(cbr_pkg::LOG_EP, ep_psr, ep_ecr);
			logged_e = ep_cnt;
		end
		if (bo_cnt != scheduled) begin
			if (logged_b != bo_cnt) begin
				n = bo_cnt - logged_b;
				if (!in_episode) begin
					add_log(cbr_pkg::LOG_BO, bo_psr, bo_ecr);
					in_episode = 1;
					if (n > 1)
						n_bosup += n - 1;
				end else begin
					n_bosup += n;
				end
				logged_b = bo_cnt;
			end
			if (verifying) begin
				verifying = 0;
				n_vfail++;
			end
			scheduled = bo_cnt;
			due_tick = it.tick + 32'(interval);
		end
		if (verifying) begin
			if (tx_cnt != snap_tx && bo_cnt == snap_bo) begin
				handled = snap_bo;
				verifying = 0;
				in_episode = 0;
				n_succ++;
				fail_step = cbr_pkg::STEP_NONE;
				fail_code = 0;
				add_log(cbr_pkg::LOG_OK, it.status, it.errcnt);
			end
			return steps;
		end
		if (scheduled == handled)
			return steps;
		diff = it.tick - due_tick;
		if (diff[31])
			return steps;
		due_tick = it.tick + 32'(interval);
		n_att++;
		if (phase == cbr_pkg::PH_STOP) begin
			steps[0] = 1;
			if (it.stop_res != 0) begin
				note_failure(cbr_pkg::STEP_STOP, it.stop_res);
				return steps;
			end
			phase = cbr_pkg::PH_START;
		end
		if (phase == cbr_pkg::PH_START) begin
			steps[1] = 1;
			if (it.start_res != 0) begin
				note_failure(cbr_pkg::STEP_START, it.start_res);
				return steps;
			end
			phase = cbr_pkg::PH_NOTIFY;
		end
		steps[2] = 1;
		if (it.notify_res != 0) begin
			note_failure(cbr_pkg::STEP_NOTIFY, it.notify_res);
			return steps;
		end
		phase = cbr_pkg::PH_STOP;
		fail_step = cbr_pkg::STEP_NONE;
		fail_code = 0;
		snap_bo = scheduled;
		snap_tx = tx_cnt;
		verifying = 1;
		return steps;
	endfunction

	function void note_item(sq_item_t it);
		logic [2:0] steps;
		log_beat_t b;
		steps = 0;
		kinds.delete(); args_a.delete(); args_b.delete();
		if (it.cmd == cbr_pkg::CMD_ERR) begin
			if (it.ep) begin
				ep_psr = it.status; ep_ecr = it.errcnt; ep_cnt++;
			end
			if (it.bo) begin
				bo_psr = it.status; bo_ecr = it.errcnt; bo_cnt++;
			end
		end else if (it.cmd == cbr_pkg::CMD_TX) begin
			if (it.tx_bits != 0)
				tx_cnt++;
		end else if (it.cmd == cbr_pkg::CMD_POLL) begin
			steps = run_poll(it);
		end
		if (kinds.size() == 0)
			add_log(cbr_pkg::LOG_NONE, 0, 0);
		foreach (kinds[i]) begin
			b.kind = kinds[i];
			b.arg_a = args_a[i];
			b.arg_b = args_b[i];
			b.last = (i == kinds.size() - 1);
			b.steps = steps;
			b.rec_pend = (scheduled != handled) || verifying;
			b.ver_pend = verifying;
			b.attempts = n_att;
			b.successes = n_succ;
			b.failures = n_fail;
			b.verify_fails = n_vfail;
			b.bo_suppressed = n_bosup;
			expected_beats.push_back(b);
		end
	endfunction

	function void check_beat(log_beat_t got);
		log_beat_t want;
		if (expected_beats.size() == 0) begin
			errors++;
			$display("%t: unexpected beat: %p", $realtime, got);
			return;
		end
		want = expected_beats.pop_front();
		if (got != want) begin
			errors++;
			$display("%t: mismatch\n  expected %p\n  actual   %p", $realtime, want, got);
		end
	endfunction
endclass

module testbench;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          cycles;
	logic        rx_quiet;
	logic        tx_quiet;
	logic [31:0] tick;
	recovery_scoreboard sb;
	log_beat_t   got;

	cbr_in_if  in_ch();
	cbr_out_if out_ch();

	can_bus_off_recovery_sequencer DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 300000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_item('{in_ch.cmd, in_ch.error_passive_flag, in_ch.bus_off_flag,
				in_ch.tx_buffer_bits, in_ch.status_reg, in_ch.error_count_reg,
				in_ch.tick_now, in_ch.stop_result, in_ch.start_result,
				in_ch.notify_result});
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.kind = out_ch.log_kind;
			got.arg_a = out_ch.log_arg_a;
			got.arg_b = out_ch.log_arg_b;
			got.last = out_ch.last;
			got.steps = out_ch.steps_issued;
			got.rec_pend = out_ch.recovery_open;
			got.ver_pend = out_ch.confirm_wait;
			got.attempts = out_ch.attempt_count;
			got.successes = out_ch.success_count;
			got.failures = out_ch.failure_count;
			got.verify_fails = out_ch.verify_fail_count;
			got.bo_suppressed = out_ch.bus_off_suppressed;
			sb.check_beat(got);
		end
	end

	// Receiver: random stall before each beat, except in quiet stretches.
	initial begin
		int n;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = rx_quiet ? 0 : $urandom_range(0, 10);
			if (n > 0) begin
				out_ch.ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	task automatic send_item(sq_item_t it);
		int n;
		n = tx_quiet ? 0 : $urandom_range(0, 10);
		if (n > 0) begin
			in_ch.valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		in_ch.cmd = it.cmd;
		in_ch.error_passive_flag = it.ep;
		in_ch.bus_off_flag = it.bo;
		in_ch.tx_buffer_bits = it.tx_bits;
		in_ch.status_reg = it.status;
		in_ch.error_count_reg = it.errcnt;
		in_ch.tick_now = it.tick;
		in_ch.stop_result = it.stop_res;
		in_ch.start_result = it.start_res;
		in_ch.notify_result = it.notify_res;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_err(logic ep, logic bo);
		send_item('{cbr_pkg::CMD_ERR, ep, bo, $urandom, $urandom, $urandom, $urandom,
			2'($urandom), 2'($urandom), 2'($urandom)});
	endtask

	task automatic send_tx(logic [31:0] bits);
		send_item('{cbr_pkg::CMD_TX, 1'($urandom), 1'($urandom), bits, $urandom,
			$urandom, $urandom, 2'($urandom), 2'($urandom), 2'($urandom)});
	endtask

	task automatic send_poll(logic [1:0] s0, logic [1:0] s1, logic [1:0] s2);
		send_item('{cbr_pkg::CMD_POLL, 1'($urandom), 1'($urandom), $urandom, $urandom,
			$urandom, tick, s0, s1, s2});
	endtask

	function automatic logic [1:0] pick_result();
		return ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
	endfunction

	task automatic settle_and_config(logic [15:0] value);
		in_ch.valid = 1'b0;
		while (sb.expected_beats.size() != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		sb.interval = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_phase(int count, logic [15:0] ival);
		int done;
		int r;
		done = 0;
		while (done < count) begin
			r = $urandom_range(0, 19);
			tick += $urandom_range(0, 32'(ival) * 2 + 3);
			if (r < 3)
				send_err(1'($urandom), 1'b1);
			else if (r < 5)
				send_err(1'b1, 1'($urandom));
			else if (r < 8)
				send_tx(($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
			else if (r < 18)
				send_poll(pick_result(), pick_result(), pick_result());
			else if (r < 19) begin
				tick = $urandom;
				send_poll(pick_result(), pick_result(), pick_result());
			end else
				send_item('{cbr_pkg::CMD_UNUSED, 1'($urandom), 1'($urandom), $urandom,
					$urandom, $urandom, $urandom, 2'($urandom), 2'($urandom),
					2'($urandom)});
			done++;
			if ($urandom_range(0, 15) == 0) begin
				rx_quiet = ~rx_quiet;
				tx_quiet = ~tx_quiet;
			end
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		rx_quiet = 1'b0;
		tx_quiet = 1'b0;
		tick = 32'd1000;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = cbr_pkg::CMD_ERR;
		in_ch.error_passive_flag = 1'b0;
		in_ch.bus_off_flag = 1'b0;
		in_ch.tx_buffer_bits = '0;
		in_ch.status_reg = '0;
		in_ch.error_count_reg = '0;
		in_ch.tick_now = '0;
		in_ch.stop_result = '0;
		in_ch.start_result = '0;
		in_ch.notify_result = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed sequence with the reset interval of 200 ticks.
		send_poll(2'd0, 2'd0, 2'd0);
		send_item('{cbr_pkg::CMD_UNUSED, 1'b1, 1'b1, '1, '1, '1, '1, 2'd3, 2'd3, 2'd3});
		send_err(1'b0, 1'b0);
		send_err(1'b1, 1'b0);
		send_tx(32'd0);
		send_tx(32'hFFFF_FFFF);
		send_err(1'b1, 1'b1);
		send_err(1'b0, 1'b1);
		send_poll(2'd0, 2'd0, 2'd0);
		tick += 100;
		send_poll(2'd0, 2'd0, 2'd0);
		tick += 100;
		send_poll(2'd1, 2'd0, 2'd0);
		tick += 200;
		send_poll(2'd1, 2'd0, 2'd0);
		tick += 200;
		send_poll(2'd0, 2'd2, 2'd0);
		tick += 200;
		send_poll(2'd0, 2'd3, 2'd3);
		tick += 200;
		send_poll(2'd0, 2'd0, 2'd0);
		send_poll(2'd0, 2'd0, 2'd0);
		send_err(1'b0, 1'b1);
		send_poll(2'd0, 2'd0, 2'd0);
		tick += 200;
		send_poll(2'd0, 2'd0, 2'd0);
		send_tx(32'h1);
		send_poll(2'd0, 2'd0, 2'd0);

		settle_and_config(16'd1);
		random_phase(40, 16'd1);
		settle_and_config(16'hFFFF);
		tick = 32'hFFFF_FF00;
		random_phase(15, 16'hFFFF);
		settle_and_config(16'd5);
		tick = 32'hFFFF_FFF0;
		random_phase(40, 16'd5);
		settle_and_config(cbr_pkg::RETRY_RESET);
		random_phase(15, cbr_pkg::RETRY_RESET);

		in_ch.valid = 1'b0;
		while (sb.expected_beats.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

@@ can_bus_off_recovery_sequencer.f @@
+incdir+src
src/cbr_pkg.sv
src/cbr_if.sv
src/cbr_front.sv
src/cbr_back.sv
src/can_bus_off_recovery_sequencer.sv
dv/testbench.sv
